// File: design/blpg_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line pixel generator package
// Shared constants, codes and types for the line pixel generator.
// ----------------------------------------------------------------------------
package blpg_pkg;

	localparam int COORD_BITS_DEF   = 12;
	localparam int SCREEN_BITS      = 12;
	localparam int ADDR_BITS        = 22;
	localparam int COLOR_BITS       = 24;
	localparam int PIXEL_COLOR_BITS = 32;
	localparam int APB_ADDR_BITS    = 3;
	localparam int APB_DATA_BITS    = 32;

	localparam logic [7:0]             ALPHA_OPAQUE = 8'hff;
	localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 12'd480;

	// Operation carried on the input tuser bit.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Register select, taken from paddr[2].
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	typedef struct packed {
		logic busy;
		logic fin;
	} step_status_t;

endpackage

// File: design/blpg_stepper.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper
// Holds the line state and advances the error term by one pixel per tick.
// ----------------------------------------------------------------------------
module blpg_stepper #(
	parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic                                tick,
	input  logic signed [COORD_BITS-1:0]        start_x,
	input  logic signed [COORD_BITS-1:0]        start_y,
	input  logic signed [COORD_BITS-1:0]        end_x_in,
	input  logic signed [COORD_BITS-1:0]        end_y_in,
	input  logic [blpg_pkg::COLOR_BITS-1:0]     rgb_color,
	output logic signed [COORD_BITS-1:0]        cur_x,
	output logic signed [COORD_BITS-1:0]        cur_y,
	output logic [blpg_pkg::COLOR_BITS-1:0]     color,
	output blpg_pkg::step_status_t              status
);

	localparam int EB = COORD_BITS + 2;
	localparam int WB = COORD_BITS + 3;

	logic signed [COORD_BITS-1:0]    cur_x_q, cur_y_q, stop_x_q, stop_y_q;
	logic [COORD_BITS-1:0]           dx_q, dy_q;
	logic                            dir_x_neg_q, dir_y_neg_q;
	logic signed [EB-1:0]            err_q;
	logic [blpg_pkg::COLOR_BITS-1:0] color_q;
	logic                            busy_q;

	logic signed [COORD_BITS:0] diff_x, diff_y;
	logic [COORD_BITS-1:0]      dx_new, dy_new;
	logic signed [EB-1:0]       err_new;
	logic signed [WB-1:0]       e2, ndy, pdx, err_nx;
	logic                       step_x, step_y, fin;

	assign diff_x  = {end_x_in[COORD_BITS-1], end_x_in} - {start_x[COORD_BITS-1], start_x};
	assign diff_y  = {end_y_in[COORD_BITS-1], end_y_in} - {start_y[COORD_BITS-1], start_y};
	assign dx_new  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
	assign dy_new  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
	assign err_new = $signed({2'b00, dx_new}) - $signed({2'b00, dy_new});

	assign e2     = $signed({err_q, 1'b0});
	assign ndy    = -$signed({3'b000, dy_q});
	assign pdx    = $signed({3'b000, dx_q});
	assign step_x = e2 > ndy;
	assign step_y = e2 < pdx;
	assign err_nx = $signed({err_q[EB-1], err_q})
	              - (step_x ? $signed({3'b000, dy_q}) : $signed(WB'(0)))
	              + (step_y ? $signed({3'b000, dx_q}) : $signed(WB'(0)));
	assign fin    = (cur_x_q == stop_x_q) && (cur_y_q == stop_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			stop_x_q    <= '0;
			stop_y_q    <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			dir_x_neg_q <= 1'b0;
			dir_y_neg_q <= 1'b0;
			err_q       <= '0;
			color_q     <= '0;
			busy_q      <= 1'b0;
		end else if (load) begin
			cur_x_q     <= start_x;
			cur_y_q     <= start_y;
			stop_x_q    <= end_x_in;
			stop_y_q    <= end_y_in;
			dx_q        <= dx_new;
			dy_q        <= dy_new;
			dir_x_neg_q <= diff_x[COORD_BITS] || (diff_x == '0);
			dir_y_neg_q <= diff_y[COORD_BITS] || (diff_y == '0);
			err_q       <= err_new;
			color_q     <= rgb_color;
			busy_q      <= 1'b1;
		end else if (tick && busy_q) begin
			if (fin) begin
				busy_q <= 1'b0;
			end else begin
				err_q <= err_nx[EB-1:0];
				if (step_x) begin
					cur_x_q <= dir_x_neg_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
				end
				if (step_y) begin
					cur_y_q <= dir_y_neg_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
				end
			end
		end
	end

	assign cur_x       = cur_x_q;
	assign cur_y       = cur_y_q;
	assign color       = color_q;
	assign status.busy = busy_q;
	assign status.fin  = fin;

endmodule

// File: design/blpg_pixel_fmt.sv
// ----------------------------------------------------------------------------
// Pixel formatter and output register
// Works out bounds, framebuffer address and ABGR colour, and holds the result.
// ----------------------------------------------------------------------------
module blpg_pixel_fmt #(
	parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      emit,
	input  logic signed [COORD_BITS-1:0]              cur_x,
	input  logic signed [COORD_BITS-1:0]              cur_y,
	input  logic [blpg_pkg::COLOR_BITS-1:0]           color,
	input  blpg_pkg::step_status_t                    status,
	input  logic [blpg_pkg::SCREEN_BITS-1:0]          screen_width,
	input  logic [blpg_pkg::SCREEN_BITS-1:0]          screen_height,
	input  logic                                      out_ready,
	output logic                                      in_ready,
	output logic                                      out_valid,
	output logic signed [COORD_BITS-1:0]              pixel_x,
	output logic signed [COORD_BITS-1:0]              pixel_y,
	output logic                                      in_bounds,
	output logic [blpg_pkg::ADDR_BITS-1:0]            pixel_address,
	output logic [blpg_pkg::PIXEL_COLOR_BITS-1:0]     pixel_color,
	output logic                                      last
);

	localparam int CW = COORD_BITS + blpg_pkg::SCREEN_BITS;
	localparam int MW = (CW > blpg_pkg::ADDR_BITS) ? CW : blpg_pkg::ADDR_BITS;

	logic [CW-1:0]                         x_u, y_u, w_u, h_u;
	logic [MW-1:0]                         addr_full;
	logic                                  inb;
	logic [blpg_pkg::ADDR_BITS-1:0]        addr;
	logic [blpg_pkg::PIXEL_COLOR_BITS-1:0] abgr;

	logic                                  valid_q;
	logic signed [COORD_BITS-1:0]          x_q, y_q;
	logic                                  inb_q, last_q;
	logic [blpg_pkg::ADDR_BITS-1:0]        addr_q;
	logic [blpg_pkg::PIXEL_COLOR_BITS-1:0] color_q;

	assign x_u = CW'($unsigned(cur_x));
	assign y_u = CW'($unsigned(cur_y));
	assign w_u = CW'(screen_width);
	assign h_u = CW'(screen_height);
	assign inb = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1] && (x_u < w_u) && (y_u < h_u);

	assign addr_full = MW'(cur_y[COORD_BITS-2:0]) * MW'(screen_width) + MW'(x_u);
	assign addr      = inb ? addr_full[blpg_pkg::ADDR_BITS-1:0] : '0;
	assign abgr      = {blpg_pkg::ALPHA_OPAQUE, color[7:0], color[15:8], color[23:16]};

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && emit) begin
			x_q     <= cur_x;
			y_q     <= cur_y;
			inb_q   <= inb;
			addr_q  <= addr;
			color_q <= abgr;
			last_q  <= status.fin;
		end
	end

	assign out_valid     = valid_q;
	assign pixel_x       = x_q;
	assign pixel_y       = y_q;
	assign in_bounds     = inb_q;
	assign pixel_address = addr_q;
	assign pixel_color   = color_q;
	assign last          = last_q;

endmodule

// File: design/bresenham_line_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// Bresenham line pixel generator core
// Loads a line from its endpoints and colour, then emits one pixel per tick while the line is busy.
// ----------------------------------------------------------------------------
// The core takes one request per clock, loads and ticks alike, while no
// pixel waits on a stalled output; a line of N pixels thus streams out
// from N consecutive ticks, each pixel in the cycle after its tick. The
// rate is set by the stepper's error update, registered on each tick;
// the pixel address multiply sits between the line state and the output
// register. While a pixel waits on a stalled output, the input is held
// off as well, and is let in again in the cycle that the pixel is taken.
module bresenham_line_pixel_generator_core #(
	parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF,
	localparam int IN_DATA_BITS  = ((4 * COORD_BITS + blpg_pkg::COLOR_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_BITS = ((2 * COORD_BITS + blpg_pkg::ADDR_BITS
	                                + blpg_pkg::PIXEL_COLOR_BITS + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [blpg_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [blpg_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [blpg_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// start_x, start_y, end_x_in, end_y_in, rgb_color, zero fill
	input  logic [IN_DATA_BITS-1:0]              s_tdata,
	// op
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// pixel_x, pixel_y, pixel_address, pixel_color, zero fill
	output logic [OUT_DATA_BITS-1:0]             m_tdata,
	// in_bounds
	output logic                                 m_tuser,
	output logic                                 m_tlast
);

	localparam int C = COORD_BITS;

	logic [blpg_pkg::SCREEN_BITS-1:0] width_q, height_q;
	logic                             cfg_wr, accept, load, tick, emit;

	logic signed [C-1:0]                   cur_x, cur_y, pixel_x, pixel_y;
	logic [blpg_pkg::COLOR_BITS-1:0]       color;
	blpg_pkg::step_status_t                status;
	logic                                  in_bounds;
	logic [blpg_pkg::ADDR_BITS-1:0]        pixel_address;
	logic [blpg_pkg::PIXEL_COLOR_BITS-1:0] pixel_color;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= blpg_pkg::WIDTH_RESET;
			height_q <= blpg_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				blpg_pkg::REG_SCREEN_WIDTH:  width_q  <= pwdata[blpg_pkg::SCREEN_BITS-1:0];
				blpg_pkg::REG_SCREEN_HEIGHT: height_q <= pwdata[blpg_pkg::SCREEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			blpg_pkg::REG_SCREEN_WIDTH:  prdata = blpg_pkg::APB_DATA_BITS'(width_q);
			blpg_pkg::REG_SCREEN_HEIGHT: prdata = blpg_pkg::APB_DATA_BITS'(height_q);
			default:                     prdata = '0;
		endcase
	end

	assign accept = s_tvalid && s_tready;
	assign load   = accept && (s_tuser == blpg_pkg::OP_LOAD);
	assign tick   = accept && (s_tuser == blpg_pkg::OP_TICK);
	assign emit   = tick && status.busy;

	blpg_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.tick      (tick),
		.start_x   (s_tdata[C-1:0]),
		.start_y   (s_tdata[2*C-1:C]),
		.end_x_in  (s_tdata[3*C-1:2*C]),
		.end_y_in  (s_tdata[4*C-1:3*C]),
		.rgb_color (s_tdata[4*C+blpg_pkg::COLOR_BITS-1:4*C]),
		.cur_x     (cur_x),
		.cur_y     (cur_y),
		.color     (color),
		.status    (status)
	);

	blpg_pixel_fmt #(.COORD_BITS(COORD_BITS)) u_fmt (
		.clk           (clk),
		.arst_n        (arst_n),
		.emit          (emit),
		.cur_x         (cur_x),
		.cur_y         (cur_y),
		.color         (color),
		.status        (status),
		.screen_width  (width_q),
		.screen_height (height_q),
		.out_ready     (m_tready),
		.in_ready      (s_tready),
		.out_valid     (m_tvalid),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.in_bounds     (in_bounds),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.last          (m_tlast)
	);

	assign m_tdata = OUT_DATA_BITS'({pixel_color, pixel_address, pixel_y, pixel_x});
	assign m_tuser = in_bounds;

endmodule

// File: design/blpg_checker.sv
// ----------------------------------------------------------------------------
// Bresenham line pixel generator checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module blpg_checker #(
	parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF,
	localparam int OUT_DATA_BITS = ((2 * COORD_BITS + blpg_pkg::ADDR_BITS
	                                + blpg_pkg::PIXEL_COLOR_BITS + 7) / 8) * 8,
	localparam int ADDR_LO  = 2 * COORD_BITS,
	localparam int COLOR_LO = ADDR_LO + blpg_pkg::ADDR_BITS
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic                     s_tuser,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_DATA_BITS-1:0] m_tdata,
	input logic                     m_tuser,
	input logic                     m_tlast
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Output request dropped while stalled.");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("Output request changed while stalled.");

	a_off_screen_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[COLOR_LO-1:ADDR_LO] == '0)
		else $error("Off-screen pixel carries a non-zero address.");

	a_alpha_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[COLOR_LO+31:COLOR_LO+24] == blpg_pkg::ALPHA_OPAQUE)
		else $error("Pixel colour alpha is not opaque.");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == blpg_pkg::OP_LOAD) && (!m_tvalid || m_tready)
		|=> !m_tvalid)
		else $error("A line load produced a pixel.");

endmodule

bind bresenham_line_pixel_generator_core blpg_checker #(.COORD_BITS(COORD_BITS)) u_blpg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
